[rtl/core/lu_pkg.sv]
// ----------------------------------------------------------------------------
// lu_pkg
// Shared types and constants for the fixed-point LU linear solver.
// ----------------------------------------------------------------------------
package lu_pkg;

  localparam int MAX_N     = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_N);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH2    = MAX_N * MAX_N;
  localparam int SIZE_LIM  = (MAX_N < 16) ? MAX_N : 16;

  localparam logic [1:0] REQ_MAT   = 2'd0;
  localparam logic [1:0] REQ_RHS   = 2'd1;
  localparam logic [1:0] REQ_SOLVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SING = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // saturate a 64-bit signed value to 32 bits, flag reports clamping
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) r = {1'b1, S32_MAX};
    else if (v < -64'sd2147483648) r = {1'b1, S32_MIN};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic [63:0] dividend;  // magnitude
    logic [31:0] divisor;   // magnitude
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

[rtl/core/lu_ram.sv]
// ----------------------------------------------------------------------------
// lu_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lu_div.sv]
// ----------------------------------------------------------------------------
// lu_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lu_div (
  input  logic             clk,
  input  logic             rst,
  input  lu_pkg::div_req_t req,
  output lu_pkg::div_rsp_t rsp
);

  logic [63:0] quot;
  logic [63:0] dvd;
  logic [32:0] rem;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  always_comb begin
    trial = {rem[31:0], dvd[63]} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        quot <= '0;
      end else if (busy) begin
        dvd <= {dvd[62:0], 1'b0};
        if (!trial[32]) begin
          rem  <= trial;
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= {rem[31:0], dvd[63]};
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

[rtl/core/lu_linear_solve_core.sv]
// ----------------------------------------------------------------------------
// lu_linear_solve_core
// Fixed-point Q16.16 solver for A x = b by Doolittle LU without pivoting.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata {value,col,row}, tuser req_type
//  m_axis    out  m_axis_tvalid/tready   tdata {x_value,out_index}, tuser status
//  cfg       in   cfg_we                 matrix_size
//
// Load beats are accepted only while idle. A solve runs each multiply-subtract
// step through S_RDK, S_RDK2, S_MUL and S_SUB, and each division on the shared
// divider; each output beat reads x[i] in S_ORD and is sent from S_OUT.
// rst is synchronous; stores hold no reset, unwritten A and rhs entries read
// as zero through per-entry valid bits. s_axis_tready is low for a whole
// solve and while results wait on m_axis.
// ----------------------------------------------------------------------------
module lu_linear_solve_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row_index[3:0], col_index[7:4], value[39:8]
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_index[3:0], x_value[35:4], zero[39:36]
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast
);

  localparam int IW = lu_pkg::IDX_W;
  localparam int AW = lu_pkg::ADDR_W;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ELEM  = 14'b00000000000010,  // issue read of A[i][j] / rhs
    S_ACC   = 14'b00000000000100,  // latch accumulator init
    S_RDK   = 14'b00000000001000,  // issue read of left operand
    S_RDK2  = 14'b00000000010000,  // latch left, issue read right
    S_MUL   = 14'b00000000100000,  // latch right, multiply
    S_SUB   = 14'b00000001000000,  // saturate product, subtract
    S_DRD   = 14'b00000010000000,  // read divisor
    S_DST   = 14'b00000100000000,  // start division
    S_DWT   = 14'b00001000000000,  // wait divider
    S_WR    = 14'b00010000000000,  // write result
    S_ORD   = 14'b00100000000000,  // read x[i] for the next beat
    S_OUT   = 14'b01000000000000,
    S_SING  = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] { PH_LU = 2'd0, PH_FWD = 2'd1, PH_BWD = 2'd2 } phase_t;

  state_t state;
  phase_t phase;

  logic [4:0] matrix_size;
  logic [4:0] n;
  logic [IW-1:0] i, j, k;
  logic          kdone;
  logic          sat;
  logic signed [31:0] acc, opa;
  logic signed [63:0] prod;
  logic               neg;

  logic [lu_pkg::DEPTH2-1:0] a_valid;
  logic [lu_pkg::MAX_N-1:0]  b_valid;

  // memories
  logic          a_we, f_we, b_we, w_we;
  logic [AW-1:0] a_waddr, a_raddr, f_waddr, f_raddr;
  logic [IW-1:0] b_waddr, b_raddr, w_waddr, w_raddr;
  logic [31:0]   a_wdata, f_wdata, b_wdata, w_wdata;
  logic [31:0]   a_rdata, f_rdata, b_rdata, w_rdata;
  logic          a_rv, b_rv;

  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::DEPTH2)) u_a (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata));
  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::DEPTH2)) u_f (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata));
  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::MAX_N)) u_b (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));
  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::MAX_N)) u_w (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata));

  lu_pkg::div_req_t dreq;
  lu_pkg::div_rsp_t drsp;
  lu_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  logic [1:0]          in_req;
  logic [IW-1:0]       in_row, in_col;
  logic [31:0]         in_val;
  logic                in_fire;
  assign in_req  = s_axis_tuser;
  assign in_row  = s_axis_tdata[IW-1:0];
  assign in_col  = s_axis_tdata[4+IW-1:4];
  assign in_val  = s_axis_tdata[39:8];
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // write ports
  assign a_we    = in_fire && in_req == lu_pkg::REQ_MAT;
  assign a_waddr = {in_row, in_col};
  assign a_wdata = in_val;
  assign b_we    = in_fire && in_req == lu_pkg::REQ_RHS;
  assign b_waddr = in_row;
  assign b_wdata = in_val;

  logic signed [31:0] res;
  logic [32:0]        sub_r;
  logic [32:0]        mul_r;
  logic [63:0]        pmag;
  logic signed [63:0] pshift;
  logic [32:0]        div_r;
  logic signed [63:0] qs;

  // product: magnitude truncated toward zero
  always_comb begin
    pmag   = prod[63] ? (64'd0 - prod) : prod;
    pmag   = pmag >> lu_pkg::FRAC_BITS;
    pshift = prod[63] ? -$signed(pmag) : $signed(pmag);
    mul_r  = lu_pkg::sat32(pshift);
    sub_r  = lu_pkg::sat32(64'(acc) - 64'($signed(mul_r[31:0])));
    qs     = neg ? -$signed(drsp.quot) : $signed(drsp.quot);
    div_r  = lu_pkg::sat32(drsp.quot[63] ? (neg ? 64'sh8000000000000000
                                                : 64'sh7fffffffffffffff) : qs);
  end

  // pending reads (j index for the lower triangle divisor etc.)
  logic lower;
  assign lower = (phase == PH_LU) && (i > j);

  always_comb begin
    a_raddr = {i, j};
    b_raddr = i;
    f_raddr = {i, j};
    w_raddr = j;
    unique case (state)
      S_RDK: begin
        unique case (phase)
          PH_LU:   f_raddr = {i, k};
          default: f_raddr = {i, k};
        endcase
      end
      S_RDK2: begin
        f_raddr = {k, j};
        w_raddr = k;
      end
      S_DRD: f_raddr = (phase == PH_LU) ? {j, j} : {i, i};
      S_ELEM: w_raddr = i;
      S_ORD, S_OUT: w_raddr = i;
      default: ;
    endcase
  end

  always_comb begin
    f_we = 1'b0; f_waddr = {i, j}; f_wdata = res;
    w_we = 1'b0; w_waddr = i;      w_wdata = res;
    if (state == S_WR) begin
      if (phase == PH_LU) f_we = 1'b1;
      else w_we = 1'b1;
    end
  end

  // divisor comes straight from the read port, it is only valid in S_DST
  always_comb begin
    dreq.start    = (state == S_DST);
    dreq.dividend = {(acc[31] ? 32'd0 - acc : acc), 32'd0} >> (32 - lu_pkg::FRAC_BITS);
    dreq.divisor  = f_rdata[31] ? 32'd0 - f_rdata : f_rdata;
  end

  logic [4:0] msz;
  always_comb begin
    msz = (matrix_size == 5'd0) ? 5'd1 : matrix_size;
    if (msz > 5'(lu_pkg::SIZE_LIM)) msz = 5'(lu_pkg::SIZE_LIM);
  end

  // k loop range: LU min(i,j); forward j<i (k over 0..i-1); back k over i+1..n-1
  logic [4:0] k_lim;
  always_comb begin
    unique case (phase)
      PH_LU:   k_lim = {1'b0, (i <= j) ? i : j};
      PH_FWD:  k_lim = {1'b0, i};
      default: k_lim = n;
    endcase
  end
  assign kdone = ({1'b0, k} >= k_lim);

  logic last_elem;
  logic out_load;
  logic [4:0] nm1;
  assign nm1 = n - 5'd1;
  assign out_load = ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) ||
                    (state == S_SING);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LU;
      matrix_size <= 5'd1;
      a_valid <= '0;
      b_valid <= '0;
      m_axis_tvalid <= 1'b0;
      sat <= 1'b0;
    end else begin
      if (cfg_we) matrix_size <= cfg_wdata;
      if (a_we) a_valid[{in_row, in_col}] <= 1'b1;
      if (b_we) b_valid[in_row] <= 1'b1;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_req == lu_pkg::REQ_SOLVE) begin
            n <= msz; sat <= 1'b0; phase <= PH_LU;
            i <= '0; j <= '0; state <= S_ELEM;
          end
        end
        S_ELEM: begin
          a_rv <= a_valid[{i, j}];
          b_rv <= b_valid[i];
          state <= S_ACC;
        end
        S_ACC: begin
          unique case (phase)
            PH_LU:   acc <= a_rv ? a_rdata : 32'd0;
            PH_FWD:  acc <= b_rv ? b_rdata : 32'd0;
            default: acc <= w_rdata;
          endcase
          k <= (phase == PH_BWD) ? IW'(i + 1'b1) : '0;
          state <= S_RDK;
        end
        S_RDK: begin
          if (kdone || (phase == PH_BWD && {1'b0, i} == nm1)) begin
            if (lower || phase == PH_BWD) state <= S_DRD;
            else begin res <= acc; state <= S_WR; end
          end else state <= S_RDK2;
        end
        S_RDK2: begin
          opa <= f_rdata;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= 64'(opa) * 64'((phase == PH_LU) ? $signed(f_rdata) : $signed(w_rdata));
          state <= S_SUB;
        end
        S_SUB: begin
          acc <= sub_r[31:0];
          if (mul_r[32] || sub_r[32]) sat <= 1'b1;
          k <= k + 1'b1;
          if ({1'b0, k} == nm1) begin
            if (lower || phase == PH_BWD) state <= S_DRD;
            else begin res <= sub_r[31:0]; state <= S_WR; end
          end else state <= S_RDK;
        end
        S_DRD: state <= S_DST;
        S_DST: begin
          neg <= acc[31] ^ f_rdata[31];
          state <= S_DWT;
        end
        S_DWT: begin
          if (drsp.done) begin
            res <= div_r[31:0];
            if (div_r[32]) sat <= 1'b1;
            state <= S_WR;
          end
        end
        S_WR: begin
          if (phase == PH_LU) begin
            if (i == j && res == 32'd0) state <= S_SING;
            else begin
              state <= S_ELEM;
              if ({1'b0, j} == nm1) begin
                j <= '0;
                if ({1'b0, i} == nm1) begin phase <= PH_FWD; i <= '0; end
                else i <= i + 1'b1;
              end else j <= j + 1'b1;
            end
          end else if (phase == PH_FWD) begin
            state <= S_ELEM;
            if ({1'b0, i} == nm1) begin phase <= PH_BWD; i <= nm1[IW-1:0]; end
            else i <= i + 1'b1;
          end else begin
            if (i == '0) state <= S_ORD;
            else begin i <= i - 1'b1; state <= S_ELEM; end
          end
        end
        S_ORD: state <= S_OUT;
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {4'd0, w_rdata, i};
            m_axis_tuser  <= sat ? lu_pkg::ST_SAT : lu_pkg::ST_OK;
            m_axis_tlast  <= ({1'b0, i} == nm1);
            if ({1'b0, i} == nm1) state <= S_IDLE;
            else begin
              i <= i + 1'b1;
              state <= S_ORD;
            end
          end
        end
        S_SING: begin
          m_axis_tdata  <= '0;
          m_axis_tuser  <= lu_pkg::ST_SING;
          m_axis_tlast  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign last_elem = m_axis_tlast;

  property p_no_in_busy;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !s_axis_tready;
  endproperty
  a_no_in_busy: assert property (p_no_in_busy) else $error("input taken mid-solve");

  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == lu_pkg::ST_SING) |-> m_axis_tlast)
    else $error("singular beat without last");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy) else $error("divider restarted while busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && last_elem) |=> !m_axis_tvalid || state == S_IDLE)
    else $error("beat after last");

endmodule
